@@ rtl/audio_fill_ramp_sequencer_core_defines.svh @@
// Assertion macros shared by the checker of the audio fill ramp sequencer.
`ifndef AUDIO_FILL_RAMP_SEQUENCER_CORE_DEFINES_SVH
`define AUDIO_FILL_RAMP_SEQUENCER_CORE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define AFRS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afrs assertion failed");

// Consequent checked in the cycle after the antecedent.
`define AFRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afrs assertion failed");

`endif

@@ rtl/afrs_pkg.sv @@
// Package of types, constants and helpers for the audio fill ramp sequencer.
`timescale 1ns / 1ps

package afrs_pkg;

  localparam int MAX_CHANNELS     = 2;
  localparam int DEFAULT_CHANNELS = 2;
  localparam int SAMPLE_W         = 32;
  localparam int RAMP_W           = 11;
  localparam int DIV_W            = RAMP_W + 1;
  localparam int PREFILL_W        = 15;
  localparam int DEADLINE_W       = 10;
  localparam int BYTES_W          = 3;
  localparam int FIFO_W           = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 15;
  localparam int PROD_W           = SAMPLE_W + RAMP_W;
  localparam int CNT_W            = $clog2(PROD_W);

  localparam logic [RAMP_W-1:0]     RESET_RAMP_FRAMES      = 11'd96;
  localparam logic [PREFILL_W-1:0]  RESET_PREFILL_FRAMES   = 15'd1920;
  localparam logic [DEADLINE_W-1:0] RESET_DEADLINE_PACKETS = 10'd50;
  localparam logic [BYTES_W-1:0]    RESET_SAMPLE_BYTES     = 3'd2;

  localparam logic [DEADLINE_W-1:0] WAIT_MAX = '1;

  localparam logic [BYTES_W-1:0]  BYTES_TWO   = 3'd2;
  localparam logic [BYTES_W-1:0]  BYTES_THREE = 3'd3;
  localparam logic [SAMPLE_W-1:0] MASK_TWO    = 32'hFFFF_0000;
  localparam logic [SAMPLE_W-1:0] MASK_THREE  = 32'hFFFF_FF00;
  localparam logic [SAMPLE_W-1:0] MASK_FULL   = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_FRAMES      = 2'd0,
    REG_PREFILL_FRAMES   = 2'd1,
    REG_DEADLINE_PACKETS = 2'd2,
    REG_SAMPLE_BYTES     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_PREFILL  = 3'd0,
    MODE_SILENCE  = 3'd1,
    MODE_APPROACH = 3'd2,
    MODE_PLAYING  = 3'd3,
    MODE_DECAY    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_EVAL = 2'd1,
    PH_RAMP = 2'd2,
    PH_FIN  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    LN_IDLE = 2'd0,
    LN_MUL  = 2'd1,
    LN_DIV  = 2'd2,
    LN_FIX  = 2'd3
  } lane_state_t;

  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_HEAD = 2'd1,
    KIND_RAMP = 2'd2
  } kind_t;

  typedef struct packed {
    logic              load_head;
    logic              load_last;
    logic              take_head;
    logic              start;
    logic [RAMP_W-1:0] k;
    logic [DIV_W-1:0]  n;
  } lane_cmd_t;

  typedef struct packed {
    logic  fin;
    kind_t kind;
    logic  pop;
    logic  und;
  } result_t;

  // Keeps the sample bits that the wire carries.
  function automatic logic [SAMPLE_W-1:0] wire_mask(input logic [BYTES_W-1:0] bytes);
    logic [SAMPLE_W-1:0] m;
    case (bytes)
      BYTES_TWO:   m = MASK_TWO;
      BYTES_THREE: m = MASK_THREE;
      default:     m = MASK_FULL;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/afrs_lane.sv @@
// One channel lane: ramp target, last sample, multiplier and serial divider.
`timescale 1ns / 1ps

module afrs_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  afrs_pkg::lane_cmd_t                  cmd,
  input  logic signed [afrs_pkg::SAMPLE_W-1:0] head,
  output logic                                 busy,
  output logic signed [afrs_pkg::SAMPLE_W-1:0] res
);

  afrs_pkg::lane_state_t state, state_next;

  logic signed [afrs_pkg::SAMPLE_W-1:0] target;
  logic signed [afrs_pkg::SAMPLE_W-1:0] last;
  logic                                 neg;
  logic [afrs_pkg::SAMPLE_W-1:0]        mag;
  logic [afrs_pkg::RAMP_W-1:0]          k_q;
  logic [afrs_pkg::DIV_W-1:0]           n_q;
  logic [afrs_pkg::PROD_W-1:0]          dq;
  logic [afrs_pkg::DIV_W-1:0]           rem;
  logic [afrs_pkg::CNT_W-1:0]           cnt;
  logic [afrs_pkg::DIV_W:0]             trial;
  logic [afrs_pkg::SAMPLE_W-1:0]        quot;

  assign trial = {rem, dq[afrs_pkg::PROD_W-1]} - {1'b0, n_q};
  assign quot  = dq[afrs_pkg::SAMPLE_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      afrs_pkg::LN_IDLE: begin
        if (cmd.start) begin
          state_next = afrs_pkg::LN_MUL;
        end
      end
      afrs_pkg::LN_MUL: state_next = afrs_pkg::LN_DIV;
      afrs_pkg::LN_DIV: begin
        if (cnt == afrs_pkg::CNT_W'(afrs_pkg::PROD_W - 1)) begin
          state_next = afrs_pkg::LN_FIX;
        end
      end
      afrs_pkg::LN_FIX: state_next = afrs_pkg::LN_IDLE;
      default:          state_next = afrs_pkg::LN_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != afrs_pkg::LN_IDLE);
    res  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= afrs_pkg::LN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      last   <= '0;
    end else begin
      if (cmd.load_head) begin
        target <= head;
      end
      if (cmd.load_last) begin
        target <= last;
      end
      if (cmd.take_head) begin
        last <= head;
      end
      if (state == afrs_pkg::LN_FIX) begin
        last <= neg ? $signed(~quot + 1'b1) : $signed(quot);
      end
    end
  end

  // Magnitude is divided and the sign put back, so the quotient truncates toward zero.
  always_ff @(posedge clk) begin
    case (state)
      afrs_pkg::LN_IDLE: begin
        if (cmd.start) begin
          neg <= target[afrs_pkg::SAMPLE_W-1];
          mag <= target[afrs_pkg::SAMPLE_W-1] ? (~target + 1'b1) : target;
          k_q <= cmd.k;
          n_q <= cmd.n;
        end
      end
      afrs_pkg::LN_MUL: begin
        dq  <= afrs_pkg::PROD_W'(mag) * afrs_pkg::PROD_W'(k_q);
        rem <= '0;
        cnt <= '0;
      end
      afrs_pkg::LN_DIV: begin
        if (!trial[afrs_pkg::DIV_W]) begin
          rem <= trial[afrs_pkg::DIV_W-1:0];
          dq  <= {dq[afrs_pkg::PROD_W-2:0], 1'b1};
        end else begin
          rem <= {rem[afrs_pkg::DIV_W-2:0], dq[afrs_pkg::PROD_W-1]};
          dq  <= {dq[afrs_pkg::PROD_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/afrs_ctrl.sv @@
// Mode sequencer: steps the playback mode once per cycle while evaluating an item, and issues lane commands.
`timescale 1ns / 1ps

module afrs_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                packet_start,
  input  logic                                flush,
  input  logic                                paused,
  input  logic [afrs_pkg::FIFO_W-1:0]         fifo_frames,
  input  logic [afrs_pkg::RAMP_W-1:0]         ramp_frames,
  input  logic [afrs_pkg::PREFILL_W-1:0]      prefill_frames,
  input  logic [afrs_pkg::DEADLINE_W-1:0]     deadline_packets,
  input  logic                                lanes_busy,
  input  logic                                out_free,
  output logic                                in_ready,
  output afrs_pkg::lane_cmd_t                 lane_cmd,
  output afrs_pkg::result_t                   result
);

  localparam logic AFTER_PREFILL = 1'b0;
  localparam logic AFTER_SILENCE = 1'b1;

  afrs_pkg::phase_t phase, phase_next;
  afrs_pkg::mode_t  mode, mode_next;
  afrs_pkg::kind_t  kind, kind_next;

  logic                            after_decay, after_decay_next;
  logic [afrs_pkg::RAMP_W-1:0]     pos, pos_next;
  logic [afrs_pkg::DEADLINE_W-1:0] prefill_wait, prefill_wait_next;
  logic                            silent, silent_next;
  logic                            paused_q, paused_q_next;
  logic [afrs_pkg::FIFO_W-1:0]     fifo_q, fifo_q_next;
  logic                            pop, pop_next;
  logic                            und, und_next;

  logic                        in_accept;
  logic                        fifo_nz;
  logic                        avail;
  logic                        start_ok;
  logic                        ramp_ok;
  logic [afrs_pkg::DIV_W-1:0]  pos_inc;
  logic                        last_frame;
  logic [afrs_pkg::RAMP_W-1:0] decay_k;
  logic                        running;
  logic                        flush_decay;

  assign in_accept   = in_valid && (phase == afrs_pkg::PH_IDLE);
  assign fifo_nz     = (fifo_q != '0);
  assign avail       = !paused_q && fifo_nz;
  assign start_ok    = avail && ((fifo_q >= afrs_pkg::FIFO_W'(prefill_frames))
                                 || (prefill_wait >= deadline_packets));
  assign ramp_ok     = (pos < ramp_frames);
  assign pos_inc     = {1'b0, pos} + 1'b1;
  assign last_frame  = (pos_inc >= {1'b0, ramp_frames});
  assign decay_k     = ramp_frames - pos - 1'b1;
  assign running     = (phase == afrs_pkg::PH_EVAL) && !silent;
  assign flush_decay = in_accept && flush
                       && (mode == afrs_pkg::MODE_PLAYING || mode == afrs_pkg::MODE_APPROACH);

  // Next state.
  always_comb begin
    phase_next        = phase;
    mode_next         = mode;
    kind_next         = kind;
    after_decay_next  = after_decay;
    pos_next          = pos;
    prefill_wait_next = prefill_wait;
    silent_next       = silent;
    paused_q_next     = paused_q;
    fifo_q_next       = fifo_q;
    pop_next          = pop;
    und_next          = und;
    case (phase)
      afrs_pkg::PH_IDLE: begin
        if (in_accept) begin
          paused_q_next = paused;
          fifo_q_next   = fifo_frames;
          pop_next      = 1'b0;
          und_next      = 1'b0;
          if (packet_start) begin
            silent_next = 1'b0;
          end
          if (flush) begin
            if (flush_decay) begin
              pos_next         = '0;
              after_decay_next = AFTER_PREFILL;
              mode_next        = afrs_pkg::MODE_DECAY;
            end else if (mode == afrs_pkg::MODE_DECAY) begin
              after_decay_next = AFTER_PREFILL;
            end else begin
              mode_next = afrs_pkg::MODE_PREFILL;
            end
            prefill_wait_next = '0;
          end
          phase_next = afrs_pkg::PH_EVAL;
        end
      end
      afrs_pkg::PH_EVAL: begin
        if (silent) begin
          kind_next  = afrs_pkg::KIND_ZERO;
          phase_next = afrs_pkg::PH_FIN;
        end else begin
          case (mode)
            afrs_pkg::MODE_PREFILL: begin
              if (start_ok) begin
                mode_next         = afrs_pkg::MODE_APPROACH;
                pos_next          = '0;
                prefill_wait_next = '0;
              end else begin
                if (avail && prefill_wait != afrs_pkg::WAIT_MAX) begin
                  prefill_wait_next = prefill_wait + 1'b1;
                end
                silent_next = 1'b1;
                kind_next   = afrs_pkg::KIND_ZERO;
                phase_next  = afrs_pkg::PH_FIN;
              end
            end
            afrs_pkg::MODE_SILENCE: begin
              if (avail) begin
                mode_next         = afrs_pkg::MODE_APPROACH;
                pos_next          = '0;
                prefill_wait_next = '0;
              end else begin
                silent_next = 1'b1;
                kind_next   = afrs_pkg::KIND_ZERO;
                phase_next  = afrs_pkg::PH_FIN;
              end
            end
            afrs_pkg::MODE_APPROACH: begin
              if (ramp_ok) begin
                pos_next   = pos_inc[afrs_pkg::RAMP_W-1:0];
                if (last_frame) begin
                  mode_next = afrs_pkg::MODE_PLAYING;
                end
                kind_next  = afrs_pkg::KIND_RAMP;
                phase_next = afrs_pkg::PH_RAMP;
              end else begin
                mode_next = afrs_pkg::MODE_PLAYING;
              end
            end
            afrs_pkg::MODE_PLAYING: begin
              if (!paused_q && fifo_nz) begin
                pop_next   = 1'b1;
                kind_next  = afrs_pkg::KIND_HEAD;
                phase_next = afrs_pkg::PH_FIN;
              end else begin
                if (!paused_q) begin
                  und_next = 1'b1;
                end
                pos_next         = '0;
                after_decay_next = AFTER_SILENCE;
                mode_next        = afrs_pkg::MODE_DECAY;
              end
            end
            afrs_pkg::MODE_DECAY: begin
              if (ramp_ok) begin
                pos_next = pos_inc[afrs_pkg::RAMP_W-1:0];
                if (last_frame) begin
                  mode_next = (after_decay == AFTER_SILENCE) ? afrs_pkg::MODE_SILENCE
                                                             : afrs_pkg::MODE_PREFILL;
                end
                kind_next  = afrs_pkg::KIND_RAMP;
                phase_next = afrs_pkg::PH_RAMP;
              end else begin
                mode_next = (after_decay == AFTER_SILENCE) ? afrs_pkg::MODE_SILENCE
                                                           : afrs_pkg::MODE_PREFILL;
              end
            end
            default: mode_next = afrs_pkg::MODE_PREFILL;
          endcase
        end
      end
      afrs_pkg::PH_RAMP: begin
        if (!lanes_busy) begin
          phase_next = afrs_pkg::PH_FIN;
        end
      end
      afrs_pkg::PH_FIN: begin
        if (out_free) begin
          phase_next = afrs_pkg::PH_IDLE;
        end
      end
      default: phase_next = afrs_pkg::PH_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready    = (phase == afrs_pkg::PH_IDLE);
    lane_cmd    = '0;
    result.fin  = (phase == afrs_pkg::PH_FIN) && out_free;
    result.kind = kind;
    result.pop  = pop;
    result.und  = und;
    if (flush_decay) begin
      lane_cmd.load_last = 1'b1;
    end
    if (running) begin
      case (mode)
        afrs_pkg::MODE_PREFILL: lane_cmd.load_head = start_ok;
        afrs_pkg::MODE_SILENCE: lane_cmd.load_head = avail;
        afrs_pkg::MODE_APPROACH: begin
          lane_cmd.start = ramp_ok;
          lane_cmd.k     = pos_inc[afrs_pkg::RAMP_W-1:0];
          lane_cmd.n     = {1'b0, ramp_frames} + 1'b1;
        end
        afrs_pkg::MODE_PLAYING: begin
          if (!paused_q && fifo_nz) begin
            lane_cmd.take_head = 1'b1;
          end else begin
            lane_cmd.load_last = 1'b1;
          end
        end
        afrs_pkg::MODE_DECAY: begin
          lane_cmd.start = ramp_ok;
          lane_cmd.k     = decay_k;
          lane_cmd.n     = {1'b0, ramp_frames};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= afrs_pkg::PH_IDLE;
      mode         <= afrs_pkg::MODE_PREFILL;
      kind         <= afrs_pkg::KIND_ZERO;
      after_decay  <= AFTER_PREFILL;
      pos          <= '0;
      prefill_wait <= '0;
      silent       <= 1'b0;
      pop          <= 1'b0;
      und          <= 1'b0;
    end else begin
      phase        <= phase_next;
      mode         <= mode_next;
      kind         <= kind_next;
      after_decay  <= after_decay_next;
      pos          <= pos_next;
      prefill_wait <= prefill_wait_next;
      silent       <= silent_next;
      pop          <= pop_next;
      und          <= und_next;
    end
  end

  always_ff @(posedge clk) begin
    paused_q <= paused_q_next;
    fifo_q   <= fifo_q_next;
  end

endmodule

@@ rtl/audio_fill_ramp_sequencer_core.sv @@
// Top level of the audio fill ramp sequencer: registers, lanes, merge and output stage.
// A zero or head frame needs no lane work; a ramp frame waits for the 43-step serial
// divider in each lane. One item is in flight at a time; the next is taken in the cycle
// after the result enters the output register. Synchronous reset sets prefill mode,
// clears ramp and sample state and loads the register defaults.
`timescale 1ns / 1ps

module audio_fill_ramp_sequencer_core #(
  parameter int CHANNELS = afrs_pkg::DEFAULT_CHANNELS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  packet_start,
  input  logic                                  flush,
  input  logic                                  paused,
  input  logic [afrs_pkg::FIFO_W-1:0]           fifo_frames,
  input  logic signed [afrs_pkg::SAMPLE_W-1:0]  head_sample_0,
  input  logic signed [afrs_pkg::SAMPLE_W-1:0]  head_sample_1,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [afrs_pkg::SAMPLE_W-1:0]  out_sample_0,
  output logic signed [afrs_pkg::SAMPLE_W-1:0]  out_sample_1,
  output logic                                  pop_res,
  output logic                                  underrun,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [afrs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [afrs_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Configuration registers. Writes are always taken; the user must make them only while
  // the block is idle, so no item ever sees a register change under it. The block does not enforce this.
  logic [afrs_pkg::RAMP_W-1:0]     ramp_frames;
  logic [afrs_pkg::PREFILL_W-1:0]  prefill_frames;
  logic [afrs_pkg::DEADLINE_W-1:0] deadline_packets;
  logic [afrs_pkg::BYTES_W-1:0]    sample_bytes;

  logic [afrs_pkg::SAMPLE_W-1:0] mask;
  logic                          in_accept;
  logic                          out_free;
  logic                          lanes_busy;

  afrs_pkg::lane_cmd_t lane_cmd;
  afrs_pkg::result_t   result;

  logic signed [afrs_pkg::SAMPLE_W-1:0] head_in  [afrs_pkg::MAX_CHANNELS];
  logic signed [afrs_pkg::SAMPLE_W-1:0] head_q   [afrs_pkg::MAX_CHANNELS];
  logic signed [afrs_pkg::SAMPLE_W-1:0] lane_res [afrs_pkg::MAX_CHANNELS];
  logic signed [afrs_pkg::SAMPLE_W-1:0] merged   [afrs_pkg::MAX_CHANNELS];
  logic [afrs_pkg::MAX_CHANNELS-1:0]    lane_busy;

  assign cfg_ready  = 1'b1;
  assign mask       = afrs_pkg::wire_mask(sample_bytes);
  assign in_accept  = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign lanes_busy = |lane_busy;
  assign head_in[0] = head_sample_0;
  assign head_in[1] = head_sample_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_frames      <= afrs_pkg::RESET_RAMP_FRAMES;
      prefill_frames   <= afrs_pkg::RESET_PREFILL_FRAMES;
      deadline_packets <= afrs_pkg::RESET_DEADLINE_PACKETS;
      sample_bytes     <= afrs_pkg::RESET_SAMPLE_BYTES;
    end else if (cfg_valid && cfg_ready) begin
      case (afrs_pkg::cfg_reg_t'(cfg_index))
        afrs_pkg::REG_RAMP_FRAMES:      ramp_frames      <= cfg_data[afrs_pkg::RAMP_W-1:0];
        afrs_pkg::REG_PREFILL_FRAMES:   prefill_frames   <= cfg_data[afrs_pkg::PREFILL_W-1:0];
        afrs_pkg::REG_DEADLINE_PACKETS: deadline_packets <= cfg_data[afrs_pkg::DEADLINE_W-1:0];
        afrs_pkg::REG_SAMPLE_BYTES:     sample_bytes     <= cfg_data[afrs_pkg::BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The sequencer walks the mode machine one transition per cycle until the
  // slot is decided, then answers once the lanes (for a ramp) and the output register are free.
  afrs_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .packet_start     (packet_start),
    .flush            (flush),
    .paused           (paused),
    .fifo_frames      (fifo_frames),
    .ramp_frames      (ramp_frames),
    .prefill_frames   (prefill_frames),
    .deadline_packets (deadline_packets),
    .lanes_busy       (lanes_busy),
    .out_free         (out_free),
    .in_ready         (in_ready),
    .lane_cmd         (lane_cmd),
    .result           (result)
  );

  // One lane per channel. Every lane receives the same command, so all of them
  // start and finish their ramp division in the same cycles. The head frame is
  // cut to the wire width as the item is taken. Channels beyond CHANNELS read
  // as silence.
  for (genvar g = 0; g < afrs_pkg::MAX_CHANNELS; g++) begin : g_lane
    if (g < CHANNELS) begin : g_used
      always_ff @(posedge clk) begin
        if (in_accept) begin
          head_q[g] <= $signed(head_in[g] & mask);
        end
      end

      afrs_lane u_lane (
        .clk  (clk),
        .rst  (rst),
        .cmd  (lane_cmd),
        .head (head_q[g]),
        .busy (lane_busy[g]),
        .res  (lane_res[g])
      );
    end else begin : g_unused
      assign head_q[g]    = '0;
      assign lane_res[g]  = '0;
      assign lane_busy[g] = 1'b0;
    end
  end

  // Merge stage: pick silence, the head frame or the lanes' ramp values. Ramp
  // values are kept at full precision inside the lanes and only cut to the
  // wire width here.
  always_comb begin
    for (int ch = 0; ch < afrs_pkg::MAX_CHANNELS; ch++) begin
      case (result.kind)
        afrs_pkg::KIND_ZERO: merged[ch] = '0;
        afrs_pkg::KIND_HEAD: merged[ch] = head_q[ch];
        afrs_pkg::KIND_RAMP: merged[ch] = $signed(lane_res[ch] & mask);
        default:             merged[ch] = '0;
      endcase
    end
  end

  // Output register. It holds a finished item until the consumer takes it,
  // while the sequencer is already free to accept the next item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.fin) begin
      out_sample_0 <= merged[0];
      out_sample_1 <= merged[1];
      pop_res      <= result.pop;
      underrun     <= result.und;
    end
  end

endmodule

@@ rtl/afrs_checker.sv @@
// Port-level checker for the audio fill ramp sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "audio_fill_ramp_sequencer_core_defines.svh"

module afrs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [afrs_pkg::SAMPLE_W-1:0] out_sample_0,
  input logic [afrs_pkg::SAMPLE_W-1:0] out_sample_1,
  input logic                          pop_res,
  input logic                          underrun
);

  // Whole contents of the output item, for the hold check.
  logic [2*afrs_pkg::SAMPLE_W+1:0] out_word;

  assign out_word = {out_sample_0, out_sample_1, pop_res, underrun};

  // A result held back by the consumer keeps its contents.
  `AFRS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))

  // Only one item is worked on at a time.
  `AFRS_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // A slot cannot both consume a frame and report the FIFO as dry.
  `AFRS_ASSERT_NOW(a_pop_xor_underrun, clk, rst, out_valid, !(pop_res && underrun))

  // Nothing is offered straight after reset.
  `AFRS_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !out_valid)

endmodule

bind audio_fill_ramp_sequencer_core afrs_checker u_afrs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_sample_0 (out_sample_0),
  .out_sample_1 (out_sample_1),
  .pop_res      (pop_res),
  .underrun     (underrun)
);
